// ----- src/srl_pkg.sv -----
`default_nettype none

package srl_pkg;

   localparam int CoordBitsDefault = 12;
   localparam int ColorBits = 32;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP = 1'b1;

   typedef struct packed {
      logic load;
      logic step;
      logic div;
      logic fix;
   } srl_cmd_type;

   typedef struct packed {
      logic out_hold;
   } srl_sts_type;

endpackage

`default_nettype wire

// ----- src/srl_ctrl.sv -----
`default_nettype none

module srl_ctrl
   import srl_pkg::*;
#(
   parameter int DIV_STEPS = CoordBitsDefault + 1
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_type,
   output logic             req_ready,
   input  wire srl_sts_type sts,
   output srl_cmd_type      cmd
);

   localparam int CntBits = $clog2(DIV_STEPS + 1);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV = 2'd1;
   localparam logic [1:0] ST_FIX = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic accept;

   assign req_ready = (state_ff == ST_IDLE) && !sts.out_hold;
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_START) begin
                  cmd.load = 1'b1;
                  cnt_in = '0;
                  state_in = ST_DIV;
               end else begin
                  cmd.step = 1'b1;
               end
            end
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntBits'(DIV_STEPS - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.fix = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/srl_dp.sv -----
`default_nettype none

module srl_dp
   import srl_pkg::*;
#(
   parameter int COORD_BITS = CoordBitsDefault
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire srl_cmd_type                  cmd,
   output srl_sts_type                       sts,
   input  wire logic signed [COORD_BITS-1:0] req_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_end_y,
   input  wire logic [ColorBits-1:0]         req_line_color,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0]      rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]      rsp_pixel_y,
   output logic [ColorBits-1:0]              rsp_pixel_color,
   output logic                              rsp_last_pixel
);

   localparam int CW = COORD_BITS;
   localparam int DW = COORD_BITS + 1;

   logic active_ff;
   logic [CW-1:0] cur_x_ff, final_x_ff;
   logic [DW-1:0] rise_ff, run_ff;
   logic [ColorBits-1:0] color_ff;
   logic [DW-1:0] acc_ff, r_ff;
   logic [DW-1:0] qstep_ff, rstep_ff;
   logic [DW:0] rem_ff;
   logic [DW-1:0] quo_ff;
   logic rsp_valid_ff;
   logic [CW-1:0] px_ff, py_ff;
   logic [ColorBits-1:0] pc_ff;
   logic last_ff;

   logic [DW-1:0] x0e, y0e, x1e, y1e, dx, rise_new, rise_mag;
   logic [DW:0] shifted;
   logic [DW+1:0] diff;
   logic emit, last, adj, wrap;
   logic [DW-1:0] y_full;
   logic [DW:0] sum_r;

   assign x0e = {req_start_x[CW-1], req_start_x};
   assign y0e = {req_start_y[CW-1], req_start_y};
   assign x1e = {req_end_x[CW-1], req_end_x};
   assign y1e = {req_end_y[CW-1], req_end_y};
   assign dx = x1e - x0e;
   assign rise_new = y1e - y0e;
   assign rise_mag = rise_new[DW-1] ? (~rise_new + 1'b1) : rise_new;

   assign shifted = {rem_ff[DW-1:0], quo_ff[DW-1]};
   assign diff = {1'b0, shifted} - {2'b00, run_ff};

   assign emit = cmd.step && active_ff;
   assign last = (cur_x_ff == final_x_ff);
   assign adj = acc_ff[DW-1] && (r_ff != '0);
   assign y_full = acc_ff + {{(DW-1){1'b0}}, adj};
   assign sum_r = {1'b0, r_ff} + {1'b0, rstep_ff};
   assign wrap = (sum_r >= {1'b0, run_ff});

   assign sts.out_hold = rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            active_ff <= ($signed(x0e) <= $signed(x1e));
         end else if (emit && last) begin
            active_ff <= 1'b0;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_x_ff <= req_start_x;
         final_x_ff <= req_end_x;
         rise_ff <= rise_new;
         run_ff <= (dx == '0) ? DW'(1) : dx;
         color_ff <= req_line_color;
         acc_ff <= y0e;
         r_ff <= '0;
         rem_ff <= '0;
         quo_ff <= rise_mag;
      end else if (cmd.div) begin
         quo_ff <= {quo_ff[DW-2:0], ~diff[DW+1]};
         rem_ff <= diff[DW+1] ? shifted : diff[DW:0];
      end else if (cmd.fix) begin
         if (rise_ff[DW-1] && (rem_ff != '0)) begin
            qstep_ff <= ~quo_ff;
            rstep_ff <= run_ff - rem_ff[DW-1:0];
         end else if (rise_ff[DW-1]) begin
            qstep_ff <= ~quo_ff + 1'b1;
            rstep_ff <= '0;
         end else begin
            qstep_ff <= quo_ff;
            rstep_ff <= rem_ff[DW-1:0];
         end
      end else if (emit) begin
         cur_x_ff <= cur_x_ff + 1'b1;
         r_ff <= wrap ? DW'(sum_r - {1'b0, run_ff}) : sum_r[DW-1:0];
         acc_ff <= acc_ff + qstep_ff + {{(DW-1){1'b0}}, wrap};
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         px_ff <= cur_x_ff;
         py_ff <= y_full[CW-1:0];
         pc_ff <= color_ff;
         last_ff <= last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel_x = px_ff;
   assign rsp_pixel_y = py_ff;
   assign rsp_pixel_color = pc_ff;
   assign rsp_last_pixel = last_ff;

endmodule

`default_nettype wire

// ----- src/slope_line_rasterizer_top.sv -----
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  type, start/end x and y, line color
// rsp_      out        rsp_valid / rsp_ready  pixel x, pixel y, pixel color, last pixel
//
// A step beat yields one pixel when a line is active.
// A start beat runs through the accept, a restoring divide of the rise by the
// run at one quotient bit per cycle, and a floor correction.
// Reset is synchronous and active high; it drops the active line and any pixel.
// A pixel waiting in the output register blocks a new beat only if it is not
// taken in the same cycle.
`default_nettype none

module slope_line_rasterizer_top
   import srl_pkg::*;
#(
   parameter int COORD_BITS = CoordBitsDefault
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_type,
   input  wire logic signed [COORD_BITS-1:0] req_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_end_y,
   input  wire logic [ColorBits-1:0]         req_line_color,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0]      rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]      rsp_pixel_y,
   output logic [ColorBits-1:0]              rsp_pixel_color,
   output logic                              rsp_last_pixel
);

   srl_cmd_type cmd;
   srl_sts_type sts;

   srl_ctrl #(
      .DIV_STEPS(COORD_BITS + 1)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_type(req_type),
      .req_ready(req_ready),
      .sts(sts),
      .cmd(cmd)
   );

   srl_dp #(
      .COORD_BITS(COORD_BITS)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .sts(sts),
      .req_start_x(req_start_x),
      .req_start_y(req_start_y),
      .req_end_x(req_end_x),
      .req_end_y(req_end_y),
      .req_line_color(req_line_color),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pixel_x(rsp_pixel_x),
      .rsp_pixel_y(rsp_pixel_y),
      .rsp_pixel_color(rsp_pixel_color),
      .rsp_last_pixel(rsp_last_pixel)
   );

endmodule

`default_nettype wire

// ----- src/srl_checker.sv -----
`default_nettype none

module srl_checker
   import srl_pkg::*;
#(
   parameter int COORD_BITS = CoordBitsDefault
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  req_type,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [COORD_BITS-1:0] rsp_pixel_x,
   input wire logic [COORD_BITS-1:0] rsp_pixel_y,
   input wire logic [ColorBits-1:0]  rsp_pixel_color,
   input wire logic                  rsp_last_pixel
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_x)
         && $stable(rsp_pixel_y) && $stable(rsp_pixel_color) && $stable(rsp_last_pixel))
      else $error("pixel beat changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("pixel valid right after reset");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == REQ_START) |=> !req_ready)
      else $error("request taken during the slope divide");

   a_pixel_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && (req_type == REQ_STEP)))
      else $error("pixel appeared without a step beat");

endmodule

bind slope_line_rasterizer_top srl_checker #(.COORD_BITS(COORD_BITS)) u_srl_checker (.*);

`default_nettype wire
